### hw/rtl/jeti_pkg.sv
// shared types, constants and helpers of the julia escape-time iterator
`default_nettype none
package jeti_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;
	localparam int FRAC_BITS    = 28;

	// image sizes are powers of two, so the scaling is an arithmetic shift
	localparam int COL_SHIFT = $clog2(IMAGE_WIDTH);
	localparam int ROW_SHIFT = $clog2(IMAGE_HEIGHT);

	localparam int PIX_W   = 10;
	localparam int CRD_W   = 32;
	localparam int CNT_W   = 16;
	localparam int SPAN_W  = CRD_W + 1;
	localparam int PROD_W  = PIX_W + SPAN_W;
	localparam int WIDE_W  = 2 * CRD_W;

	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 32;

	localparam logic [CFG_AW-1:0] REG_ITER_LIM = 3'd0;
	localparam logic [CFG_AW-1:0] REG_C_RE     = 3'd1;
	localparam logic [CFG_AW-1:0] REG_C_IM     = 3'd2;
	localparam logic [CFG_AW-1:0] REG_MIN_X    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_MAX_X    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_MIN_Y    = 3'd5;
	localparam logic [CFG_AW-1:0] REG_MAX_Y    = 3'd6;

	localparam logic [CNT_W-1:0]        RST_ITER_LIM = 16'd256;
	localparam logic signed [CRD_W-1:0] RST_C        = 32'sd0;
	localparam logic signed [CRD_W-1:0] RST_MIN      = -32'sd536870912;
	localparam logic signed [CRD_W-1:0] RST_MAX      = 32'sd536870912;

	// escape when x^2 + y^2 >= 4.0 on the double-width squares
	localparam logic [WIDE_W-1:0] ESC_LIM = 64'd4 << (2 * FRAC_BITS);

	localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -64'sh0000_0000_8000_0000;

	// queue between front and iterator, depth a power of two
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef struct packed {
		logic [CNT_W-1:0]        iter_lim;
		logic signed [CRD_W-1:0] c_re;
		logic signed [CRD_W-1:0] c_im;
		logic signed [CRD_W-1:0] min_x;
		logic signed [CRD_W-1:0] max_x;
		logic signed [CRD_W-1:0] min_y;
		logic signed [CRD_W-1:0] max_y;
	} cfg_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
	} point_t;

	function automatic logic signed [WIDE_W-1:0] sext32(input logic signed [CRD_W-1:0] v);
		return $signed({{(WIDE_W-CRD_W){v[CRD_W-1]}}, v});
	endfunction

	function automatic logic signed [CRD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [CRD_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[CRD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[CRD_W-1:0];
		end else begin
			r = v[CRD_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/jeti_pix_if.sv
// pixel channel: signed column and row offsets
`default_nettype none
interface jeti_pix_if;
	logic                              valid;
	logic                              ready;
	logic signed [jeti_pkg::PIX_W-1:0] pixel_col;
	logic signed [jeti_pkg::PIX_W-1:0] pixel_row;

	modport source(output valid, output pixel_col, output pixel_row, input ready);
	modport sink(input valid, input pixel_col, input pixel_row, output ready);
endinterface
`default_nettype wire

### hw/rtl/jeti_res_if.sv
// result channel: iteration count and inside flag
`default_nettype none
interface jeti_res_if;
	logic                       valid;
	logic                       ready;
	logic [jeti_pkg::CNT_W-1:0] iter_count;
	logic                       inside_res;

	modport source(output valid, output iter_count, output inside_res, input ready);
	modport sink(input valid, input iter_count, input inside_res, output ready);
endinterface
`default_nettype wire

### hw/rtl/julia_escape_time_iterator.sv
// julia escape-time iterator top level: registers, front end, queue and iterator
// a pixel passes the front-end register, the queue and the iterator states to the result register
// the iterator takes a new point only when idle, after the last result is loaded
// each iteration: registered 32x32 products, then escape test and update
// front end and a four-entry queue keep taking pixels while the iterator is busy
// reset: registers take their defaults (limit 256, c = 0, range -2..2), queue and result empty
`default_nettype none
module julia_escape_time_iterator (
	input  wire                              clk,
	input  wire                              arst_n,
	jeti_pix_if.sink                         pix,
	jeti_res_if.source                       res,
	input  wire                              cfg_we,
	input  wire [jeti_pkg::CFG_AW-1:0]       cfg_addr,
	input  wire [jeti_pkg::CFG_DW-1:0]       cfg_data
);

	jeti_pkg::cfg_t     cfg_q;
	logic               push;
	logic               full;
	jeti_pkg::point_t   push_data;
	logic               q_valid;
	logic               q_pop;
	jeti_pkg::point_t   q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iter_lim <= jeti_pkg::RST_ITER_LIM;
			cfg_q.c_re     <= jeti_pkg::RST_C;
			cfg_q.c_im     <= jeti_pkg::RST_C;
			cfg_q.min_x    <= jeti_pkg::RST_MIN;
			cfg_q.max_x    <= jeti_pkg::RST_MAX;
			cfg_q.min_y    <= jeti_pkg::RST_MIN;
			cfg_q.max_y    <= jeti_pkg::RST_MAX;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				jeti_pkg::REG_ITER_LIM: cfg_q.iter_lim <= cfg_data[jeti_pkg::CNT_W-1:0];
				jeti_pkg::REG_C_RE:     cfg_q.c_re     <= $signed(cfg_data);
				jeti_pkg::REG_C_IM:     cfg_q.c_im     <= $signed(cfg_data);
				jeti_pkg::REG_MIN_X:    cfg_q.min_x    <= $signed(cfg_data);
				jeti_pkg::REG_MAX_X:    cfg_q.max_x    <= $signed(cfg_data);
				jeti_pkg::REG_MIN_Y:    cfg_q.min_y    <= $signed(cfg_data);
				jeti_pkg::REG_MAX_Y:    cfg_q.max_y    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	jeti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix       (pix),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	jeti_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	jeti_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
`default_nettype wire

### hw/rtl/jeti_front.sv
// front end: accepts pixels and maps them into the complex plane
`default_nettype none
module jeti_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  jeti_pkg::cfg_t       cfg,
	jeti_pix_if.sink             pix,
	output logic                 push,
	output jeti_pkg::point_t     push_data,
	input  wire                  full
);

	logic                                    v_s1;
	logic signed [jeti_pkg::PROD_W-1:0]      px_s1;
	logic signed [jeti_pkg::PROD_W-1:0]      py_s1;
	logic signed [jeti_pkg::SPAN_W-1:0]      span_x;
	logic signed [jeti_pkg::SPAN_W-1:0]      span_y;
	logic signed [jeti_pkg::PROD_W-1:0]      px_d;
	logic signed [jeti_pkg::PROD_W-1:0]      py_d;
	logic signed [jeti_pkg::WIDE_W-1:0]      mx_w;
	logic signed [jeti_pkg::WIDE_W-1:0]      my_w;
	logic                                    take;

	assign span_x = $signed({cfg.max_x[jeti_pkg::CRD_W-1], cfg.max_x})
		- $signed({cfg.min_x[jeti_pkg::CRD_W-1], cfg.min_x});
	assign span_y = $signed({cfg.max_y[jeti_pkg::CRD_W-1], cfg.max_y})
		- $signed({cfg.min_y[jeti_pkg::CRD_W-1], cfg.min_y});

	assign px_d = pix.pixel_col * span_x;
	assign py_d = pix.pixel_row * span_y;

	assign push      = v_s1 && !full;
	assign pix.ready = !v_s1 || !full;
	assign take      = pix.valid && pix.ready;

	// floor division by the image size, then offset and clamp
	assign mx_w = jeti_pkg::WIDE_W'(px_s1 >>> jeti_pkg::COL_SHIFT) + jeti_pkg::sext32(cfg.min_x);
	assign my_w = jeti_pkg::WIDE_W'(py_s1 >>> jeti_pkg::ROW_SHIFT) + jeti_pkg::sext32(cfg.min_y);

	assign push_data.x = jeti_pkg::sat32(mx_w);
	assign push_data.y = jeti_pkg::sat32(my_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_s1 <= px_d;
			py_s1 <= py_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/jeti_fifo.sv
// short queue of mapped points between front end and iterator
`default_nettype none
module jeti_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  jeti_pkg::point_t     push_data,
	output logic                 full,
	input  wire                  pop,
	output logic                 pop_valid,
	output jeti_pkg::point_t     pop_data
);

	jeti_pkg::point_t                mem_q [jeti_pkg::FIFO_DEPTH];
	logic [jeti_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [jeti_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [jeti_pkg::FIFO_CW-1:0]    count_q;

	assign full      = (count_q == jeti_pkg::FIFO_CW'(jeti_pkg::FIFO_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= jeti_pkg::FIFO_AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= jeti_pkg::FIFO_AW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= jeti_pkg::FIFO_CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= jeti_pkg::FIFO_CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= jeti_pkg::FIFO_CW'(jeti_pkg::FIFO_DEPTH)) else $error("queue count overrun");

endmodule
`default_nettype wire

### hw/rtl/jeti_core.sv
// iterator: z = z^2 + c until escape or limit, products registered in CHK and applied in ITER
`default_nettype none
module jeti_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  jeti_pkg::cfg_t       cfg,
	input  wire                  q_valid,
	input  jeti_pkg::point_t     q_data,
	output logic                 q_pop,
	jeti_res_if.source           res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CHK  = 4'b0010,
		ST_ITER = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                               state_q;
	state_t                               state_d;
	logic signed [jeti_pkg::CRD_W-1:0]    x_q;
	logic signed [jeti_pkg::CRD_W-1:0]    y_q;
	logic [jeti_pkg::CNT_W-1:0]           cnt_q;
	logic [jeti_pkg::WIDE_W-1:0]          xx_q;
	logic [jeti_pkg::WIDE_W-1:0]          yy_q;
	logic signed [jeti_pkg::WIDE_W-1:0]   xy_q;
	logic signed [jeti_pkg::WIDE_W-1:0]   xx_d;
	logic signed [jeti_pkg::WIDE_W-1:0]   yy_d;
	logic signed [jeti_pkg::WIDE_W-1:0]   xy_d;
	logic signed [jeti_pkg::WIDE_W-1:0]   diff_w;
	logic signed [jeti_pkg::WIDE_W-1:0]   nx_w;
	logic signed [jeti_pkg::WIDE_W-1:0]   ny_w;
	logic                                 at_limit;
	logic                                 escape;
	logic                                 res_load;
	logic                                 res_v_q;
	logic [jeti_pkg::CNT_W-1:0]           res_cnt_q;
	logic                                 res_in_q;

	assign xx_d = x_q * x_q;
	assign yy_d = y_q * y_q;
	assign xy_d = x_q * y_q;

	assign at_limit = (cnt_q >= cfg.iter_lim);
	assign escape   = ((xx_q + yy_q) >= jeti_pkg::ESC_LIM);

	assign diff_w = $signed(xx_q) - $signed(yy_q);
	assign nx_w   = (diff_w >>> jeti_pkg::FRAC_BITS) + jeti_pkg::sext32(cfg.c_re);
	assign ny_w   = (xy_q >>> (jeti_pkg::FRAC_BITS - 1)) + jeti_pkg::sext32(cfg.c_im);

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign res_load = (state_q == ST_DONE) && (!res_v_q || res.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = at_limit ? ST_DONE : ST_ITER;
			end
			ST_ITER: begin
				state_d = escape ? ST_DONE : ST_CHK;
			end
			ST_DONE: begin
				if (res_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= '0;
			end else if (state_q == ST_ITER && !escape) begin
				cnt_q <= jeti_pkg::CNT_W'(cnt_q + 1'b1);
			end
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q <= q_data.x;
			y_q <= q_data.y;
		end else if (state_q == ST_ITER && !escape) begin
			x_q <= jeti_pkg::sat32(nx_w);
			y_q <= jeti_pkg::sat32(ny_w);
		end
		if (state_q == ST_CHK) begin
			xx_q <= xx_d;
			yy_q <= yy_d;
			xy_q <= xy_d;
		end
		if (res_load) begin
			res_cnt_q <= cnt_q;
			res_in_q  <= (cnt_q == cfg.iter_lim);
		end
	end

	assign res.valid      = res_v_q;
	assign res.iter_count = res_cnt_q;
	assign res.inside_res = res_in_q;

	a_iter_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ITER |-> $past(state_q) == ST_CHK) else $error("iteration without products");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK && $past(state_q) == ST_ITER) |-> cnt_q == $past(cnt_q) + 16'd1)
		else $error("count not advanced by one");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE) else $error("pop while busy");
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> $past(state_q) == ST_DONE) else $error("result beat without finish");

endmodule
`default_nettype wire
